/* rtl/core/glre_pkg.sv */
// ----------------------------------------------------------------------------
// glre_pkg
// Shared types and constants of the Gaussian luma Roberts edge unit:
// register indexes, arithmetic constants, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package glre_pkg;

   // Field and register widths
   localparam int CFG_W_BITS = 11;
   localparam int CFG_H_BITS = 12;
   localparam int CSR_DATA_BITS = 12;
   localparam int CH_BITS = 8;
   localparam int ACC_BITS = 16;
   localparam int OCOL_BITS = 10;
   localparam int OROW_BITS = 12;

   // Register indexes
   localparam logic REG_FRAME_WIDTH = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // Reset geometry and lower clamp
   localparam logic [CFG_W_BITS-1:0] RESET_WIDTH = 11'd640;
   localparam logic [CFG_H_BITS-1:0] RESET_HEIGHT = 12'd480;
   localparam int MIN_DIM = 8;

   // Divide by 159 as multiply by reciprocal, exact for sums up to 255*159
   localparam logic [15:0] DIV159_MUL = 16'd52759;
   localparam int DIV159_SHIFT = 23;

   // Q0.16 luma weights
   localparam logic [15:0] LUMA_KR = 16'd19595;
   localparam logic [15:0] LUMA_KG = 16'd38470;
   localparam logic [15:0] LUMA_KB = 16'd7471;

   // 5x5 Gaussian kernel, sum 159
   localparam logic [3:0] GAUSS_K [0:4][0:4] = '{
      '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
      '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
      '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
      '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
      '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
   };

   typedef struct packed {
      logic [CH_BITS-1:0] red;
      logic [CH_BITS-1:0] green;
      logic [CH_BITS-1:0] blue;
   } rgb_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RGB,
      ST_BLUR,
      ST_DIV,
      ST_LMUL,
      ST_LWR,
      ST_RDB,
      ST_RDC,
      ST_CAPC,
      ST_SQ,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       rgb;
      logic       blur;
      logic       div;
      logic       lmul;
      logic       lwr;
      logic       rdb;
      logic       rdc;
      logic       capc;
      logic       sq;
      logic       root;
      logic       emit;
      logic       commit;
      logic [2:0] step;
   } cmd_type;

   typedef struct packed {
      logic ignore_now;
      logic drain_now;
      logic luma_en;
      logic edge_en;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/glre_ram.sv */
// ----------------------------------------------------------------------------
// glre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module glre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/glre_ctrl.sv */
// ----------------------------------------------------------------------------
// glre_ctrl
// Sequencer of the edge unit: steps one word through line store access,
// blur accumulation, luma, neighbor reads, square root and emission.
// ----------------------------------------------------------------------------
module glre_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  glre_pkg::status_type  status,
   output glre_pkg::cmd_type     cmd
);
   import glre_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;

   // State and step registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in = 3'd0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !status.ignore_now) begin
               state_in = status.drain_now ? ST_LWR : ST_RGB;
            end
         end
         ST_RGB: begin
            if (step_ff == 3'd4) begin
               state_in = status.luma_en ? ST_BLUR : ST_IDLE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_BLUR: begin
            if (step_ff == 3'd4) begin
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_DIV:  state_in = ST_LMUL;
         ST_LMUL: state_in = ST_LWR;
         ST_LWR:  state_in = status.edge_en ? ST_RDB : ST_IDLE;
         ST_RDB:  state_in = ST_RDC;
         ST_RDC:  state_in = ST_CAPC;
         ST_CAPC: state_in = ST_SQ;
         ST_SQ:   state_in = ST_ROOT;
         ST_ROOT: begin
            if (step_ff == 3'd7) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      cmd.step = step_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_RGB: begin
            cmd.rgb = 1'b1;
            cmd.commit = (step_ff == 3'd4) && !status.luma_en;
         end
         ST_BLUR: cmd.blur = 1'b1;
         ST_DIV:  cmd.div = 1'b1;
         ST_LMUL: cmd.lmul = 1'b1;
         ST_LWR: begin
            cmd.lwr = 1'b1;
            cmd.commit = !status.edge_en;
         end
         ST_RDB:  cmd.rdb = 1'b1;
         ST_RDC:  cmd.rdc = 1'b1;
         ST_CAPC: cmd.capc = 1'b1;
         ST_SQ:   cmd.sq = 1'b1;
         ST_ROOT: cmd.root = 1'b1;
         ST_EMIT: begin
            cmd.emit = status.out_free;
            cmd.commit = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* rtl/core/glre_dp.sv */
// ----------------------------------------------------------------------------
// glre_dp
// Datapath of the edge unit: geometry registers, raster counters, RGB and
// luma line stores, blur window, blur/luma arithmetic, bitwise square root
// and the result register.
// ----------------------------------------------------------------------------
module glre_dp #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 4095
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic                                 csr_addr,
   input  logic [glre_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 req_tuser,
   input  logic [23:0]                          req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,
   output logic                                 rsp_tlast,
   input  glre_pkg::cmd_type                    cmd,
   output glre_pkg::status_type                 status
);
   import glre_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int RGB_DEPTH = 4 << CW;
   localparam int LUMA_DEPTH = 2 << CW;

   // Geometry
   logic [CFG_W_BITS-1:0] width_ff;
   logic [CFG_H_BITS-1:0] height_ff;
   logic [CW:0]           w_ext;
   logic [RW:0]           h_ext;
   logic [CFG_W_BITS-1:0] wr_w;
   logic [CFG_H_BITS-1:0] wr_h;

   // Raster counters: input pixel, luma write, edge output
   logic [CW-1:0] ic_ff, lc_ff, ec_ff;
   logic [RW-1:0] ir_ff, lr_ff, er_ff;

   // Item flags
   rgb_type pix_ff;
   logic    drain_ff, luma_en_ff, edge_en_ff, interior_ff;
   logic    drain_now, luma_now, edge_now, interior_now;
   logic    pos_ok, frame_end, out_free;

   // Line stores
   logic [$clog2(RGB_DEPTH)-1:0]  rgb_rd_addr, rgb_wr_addr;
   logic [23:0]                   rgb_q;
   logic [$clog2(LUMA_DEPTH)-1:0] luma_rd_addr, luma_wr_addr;
   logic [CH_BITS-1:0]            luma_q;

   // Arithmetic
   rgb_type               colbuf_ff [0:2];
   rgb_type               win_ff [0:4][0:4];
   logic [ACC_BITS-1:0]   acc_r_ff, acc_g_ff, acc_b_ff;
   logic [ACC_BITS-1:0]   col_r, col_g, col_b;
   logic [CH_BITS-1:0]    q_r_ff, q_g_ff, q_b_ff;
   logic [23:0]           pr_r_ff, pr_g_ff, pr_b_ff;
   logic [23:0]           ysum;
   logic [CH_BITS-1:0]    y_wr, y_ff, ta_ff, tb_ff, tc_ff, c1, c2;
   logic [16:0]           n_ff;
   logic [7:0]            root_ff, cand;
   logic [2:0]            bitpos;
   logic [7:0]            edge_val;

   logic                  rsp_tvalid_ff, rsp_tlast_ff;
   logic [7:0]            rsp_edge_ff;
   logic [OCOL_BITS-1:0]  rsp_col_ff;
   logic [OROW_BITS-1:0]  rsp_row_ff;

   function automatic logic [CH_BITS-1:0] div159(input logic [ACC_BITS-1:0] s);
      logic [31:0] p;
      begin
         p = 32'(s) * 32'(DIV159_MUL);
         div159 = p[DIV159_SHIFT +: CH_BITS];
      end
   endfunction

   assign w_ext = (CW+1)'(width_ff);
   assign h_ext = (RW+1)'(height_ff);

   // Clamp register writes into range
   always_comb begin
      wr_w = csr_wdata[CFG_W_BITS-1:0];
      if (32'(wr_w) < MIN_DIM) begin
         wr_w = CFG_W_BITS'(MIN_DIM);
      end else if (32'(wr_w) > MAX_WIDTH) begin
         wr_w = CFG_W_BITS'(MAX_WIDTH);
      end
      wr_h = csr_wdata[CFG_H_BITS-1:0];
      if (32'(wr_h) < MIN_DIM) begin
         wr_h = CFG_H_BITS'(MIN_DIM);
      end else if (32'(wr_h) > MAX_HEIGHT) begin
         wr_h = CFG_H_BITS'(MAX_HEIGHT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (csr_we) begin
         if (csr_addr == REG_FRAME_WIDTH) begin
            width_ff <= wr_w;
         end else begin
            height_ff <= wr_h;
         end
      end
   end

   // Classify the offered word against the current raster position
   assign drain_now = (RW+1)'(ir_ff) >= h_ext;
   assign luma_now = drain_now || (ir_ff > RW'(2)) ||
                     ((ir_ff == RW'(2)) && (ic_ff >= CW'(2)));
   assign edge_now = drain_now || (ir_ff > RW'(3)) ||
                     ((ir_ff == RW'(3)) && (ic_ff >= CW'(3)));
   assign interior_now = (lr_ff >= RW'(2)) && ((RW+1)'(lr_ff) + (RW+1)'(3) <= h_ext) &&
                         (lc_ff >= CW'(2)) && ((CW+1)'(lc_ff) + (CW+1)'(3) <= w_ext);

   assign pos_ok = ((RW+1)'(er_ff) + (RW+1)'(1) < h_ext) &&
                   ((CW+1)'(ec_ff) + (CW+1)'(1) < w_ext);
   assign frame_end = ((RW+1)'(er_ff) + (RW+1)'(1) == h_ext) &&
                      ((CW+1)'(ec_ff) + (CW+1)'(1) == w_ext);
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   assign status.ignore_now = !drain_now && req_tuser;
   assign status.drain_now = drain_now;
   assign status.luma_en = luma_en_ff;
   assign status.edge_en = edge_en_ff;
   assign status.out_free = out_free;

   // Latch the word and its flags
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff.red <= req_tdata[7:0];
         pix_ff.green <= req_tdata[15:8];
         pix_ff.blue <= req_tdata[23:16];
         drain_ff <= drain_now;
         luma_en_ff <= luma_now;
         edge_en_ff <= edge_now;
         interior_ff <= interior_now;
      end
   end

   // Advance raster counters; restart on a register write or at frame end
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         ic_ff <= '0;
         ir_ff <= '0;
         lc_ff <= '0;
         lr_ff <= '0;
         ec_ff <= '0;
         er_ff <= '0;
      end else if (cmd.commit) begin
         if (drain_ff && frame_end) begin
            ic_ff <= '0;
            ir_ff <= '0;
            lc_ff <= '0;
            lr_ff <= '0;
            ec_ff <= '0;
            er_ff <= '0;
         end else begin
            if (!drain_ff) begin
               if ((CW+1)'(ic_ff) + (CW+1)'(1) == w_ext) begin
                  ic_ff <= '0;
                  ir_ff <= ir_ff + RW'(1);
               end else begin
                  ic_ff <= ic_ff + CW'(1);
               end
            end
            if (luma_en_ff) begin
               if ((CW+1)'(lc_ff) + (CW+1)'(1) == w_ext) begin
                  lc_ff <= '0;
                  lr_ff <= lr_ff + RW'(1);
               end else begin
                  lc_ff <= lc_ff + CW'(1);
               end
            end
            if (edge_en_ff) begin
               if ((CW+1)'(ec_ff) + (CW+1)'(1) == w_ext) begin
                  ec_ff <= '0;
                  er_ff <= er_ff + RW'(1);
               end else begin
                  ec_ff <= ec_ff + CW'(1);
               end
            end
         end
      end
   end

   // RGB line store: four rows, read the column then write the new pixel
   assign rgb_rd_addr = {2'(ir_ff[1:0] + cmd.step[1:0]), ic_ff};
   assign rgb_wr_addr = {ir_ff[1:0], ic_ff};

   glre_ram #(.WIDTH(24), .DEPTH(RGB_DEPTH)) u_rgb_ram (
      .clock   (clock),
      .wr_en   (cmd.rgb && (cmd.step == 3'd4)),
      .wr_addr (rgb_wr_addr),
      .wr_data (pix_ff),
      .rd_addr (rgb_rd_addr),
      .rd_data (rgb_q)
   );

   // Collect the column and shift the window
   always_ff @(posedge clock) begin
      if (cmd.rgb) begin
         if ((cmd.step != 3'd0) && (cmd.step != 3'd4)) begin
            colbuf_ff[2'(cmd.step[1:0] - 2'd1)] <= rgb_q;
         end
         if (cmd.step == 3'd4) begin
            for (int k = 0; k < 5; k++) begin
               for (int t = 0; t < 4; t++) begin
                  win_ff[k][t] <= win_ff[k][t+1];
               end
            end
            for (int k = 0; k < 3; k++) begin
               win_ff[k][4] <= colbuf_ff[k];
            end
            win_ff[3][4] <= rgb_q;
            win_ff[4][4] <= pix_ff;
         end
      end
   end

   // Weighted sum of one window column
   always_comb begin
      rgb_type    p;
      logic [3:0] wgt;
      col_r = '0;
      col_g = '0;
      col_b = '0;
      for (int k = 0; k < 5; k++) begin
         case (cmd.step)
            3'd0: begin p = win_ff[k][0]; wgt = GAUSS_K[k][0]; end
            3'd1: begin p = win_ff[k][1]; wgt = GAUSS_K[k][1]; end
            3'd2: begin p = win_ff[k][2]; wgt = GAUSS_K[k][2]; end
            3'd3: begin p = win_ff[k][3]; wgt = GAUSS_K[k][3]; end
            3'd4: begin p = win_ff[k][4]; wgt = GAUSS_K[k][4]; end
            default: begin p = win_ff[k][0]; wgt = GAUSS_K[k][0]; end
         endcase
         col_r = col_r + ACC_BITS'(p.red) * ACC_BITS'(wgt);
         col_g = col_g + ACC_BITS'(p.green) * ACC_BITS'(wgt);
         col_b = col_b + ACC_BITS'(p.blue) * ACC_BITS'(wgt);
      end
   end

   // Blur accumulate, divide, luma products
   always_ff @(posedge clock) begin
      if (cmd.blur) begin
         if (cmd.step == 3'd0) begin
            acc_r_ff <= col_r;
            acc_g_ff <= col_g;
            acc_b_ff <= col_b;
         end else begin
            acc_r_ff <= acc_r_ff + col_r;
            acc_g_ff <= acc_g_ff + col_g;
            acc_b_ff <= acc_b_ff + col_b;
         end
      end
      if (cmd.div) begin
         q_r_ff <= div159(acc_r_ff);
         q_g_ff <= div159(acc_g_ff);
         q_b_ff <= div159(acc_b_ff);
      end
      if (cmd.lmul) begin
         pr_r_ff <= 24'(LUMA_KR) * 24'(q_r_ff);
         pr_g_ff <= 24'(LUMA_KG) * 24'(q_g_ff);
         pr_b_ff <= 24'(LUMA_KB) * 24'(q_b_ff);
      end
   end

   assign ysum = pr_r_ff + pr_g_ff + pr_b_ff;
   assign y_wr = (interior_ff && !drain_ff) ? ysum[23:16] : '0;

   // Luma line store: two rows
   assign luma_wr_addr = {lr_ff[0], lc_ff};
   always_comb begin
      luma_rd_addr = {er_ff[0], ec_ff};
      if (cmd.rdb) begin
         luma_rd_addr = {er_ff[0], CW'(ec_ff + CW'(1))};
      end else if (cmd.rdc) begin
         luma_rd_addr = {~er_ff[0], ec_ff};
      end
   end

   glre_ram #(.WIDTH(CH_BITS), .DEPTH(LUMA_DEPTH)) u_luma_ram (
      .clock   (clock),
      .wr_en   (cmd.lwr),
      .wr_addr (luma_wr_addr),
      .wr_data (y_wr),
      .rd_addr (luma_rd_addr),
      .rd_data (luma_q)
   );

   // Roberts cross differences and bitwise square root
   assign c1 = (ta_ff > y_ff) ? ta_ff - y_ff : y_ff - ta_ff;
   assign c2 = (tb_ff > tc_ff) ? tb_ff - tc_ff : tc_ff - tb_ff;
   assign bitpos = 3'd7 - cmd.step;
   assign cand = root_ff | (8'd1 << bitpos);
   assign edge_val = !pos_ok ? 8'd0 : (n_ff[16] ? 8'd255 : root_ff);

   always_ff @(posedge clock) begin
      if (cmd.lwr) begin
         y_ff <= y_wr;
      end
      if (cmd.rdb) begin
         ta_ff <= luma_q;
      end
      if (cmd.rdc) begin
         tb_ff <= luma_q;
      end
      if (cmd.capc) begin
         tc_ff <= luma_q;
      end
      if (cmd.sq) begin
         n_ff <= 17'(16'(c1) * 16'(c1)) + 17'(16'(c2) * 16'(c2));
         root_ff <= '0;
      end
      if (cmd.root) begin
         if ({1'b0, 16'(cand) * 16'(cand)} <= n_ff) begin
            root_ff <= cand;
         end
      end
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_edge_ff <= edge_val;
         rsp_col_ff <= OCOL_BITS'(ec_ff);
         rsp_row_ff <= OROW_BITS'(er_ff);
         rsp_tlast_ff <= frame_end;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = {2'b00, rsp_row_ff, rsp_col_ff, rsp_edge_ff};
   assign rsp_tlast = rsp_tlast_ff;

endmodule

/* rtl/core/gaussian_luma_roberts_edge_unit.sv */
// ----------------------------------------------------------------------------
// gaussian_luma_roberts_edge_unit
// RGB pixel stream in, Gaussian-blurred luma Roberts edge stream out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per pixel in raster order (tuser low) and, after
//   the frame, drain words (tuser high) that flush the last 3 rows plus 3
//   pixels. A drain word during the pixel phase is dropped; a pixel word
//   during the drain phase acts as a drain word.
//   rsp_* returns one edge word per edge pixel in raster order, with
//   position and tlast on the frame's final pixel. Edges trail the input by
//   3 rows plus 3 pixels; the first words of a frame give no result.
//   csr_* sets frame width (index 0) and height (index 1); a write clamps
//   the value and restarts the frame. Write only while idle.
// Sequence:
//   One word at a time. An edge word steps through accept, line store
//   reads, column-serial blur, divide, luma and luma store write, neighbor
//   reads, sum of squares, bitwise square root and emit. A drain word
//   goes from accept straight to the luma store write.
// Reset and stall:
//   Reset restores 640x480 and frame start; line stores are not cleared.
//   A stalled receiver holds the result register; the block stops in its
//   emit step until the register frees, then accepts the next word.
// ----------------------------------------------------------------------------
module gaussian_luma_roberts_edge_unit #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 4095
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write port
   input  logic                                csr_we,
   input  logic                                csr_addr,
   input  logic [glre_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   // Pixel input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // red, green, blue
   input  logic                                req_tuser,  // mode
   // Edge output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,  // edge_value, out_column, out_row
   output logic                                rsp_tlast   // frame_last
);
   import glre_pkg::*;

   cmd_type    cmd;
   status_type status;

   glre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   glre_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

/* bench/glre_edge_checker.sv */
// ----------------------------------------------------------------------------
// glre_edge_checker
// Watches the configuration port and both streams of the edge unit. Keeps
// its own copy of frame geometry, line stores and blur window, works out
// the edge word each accepted input word should produce, and compares every
// edge word the unit sends against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module glre_edge_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_addr,
   input  logic [glre_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // red, green, blue
   input  logic                                req_tuser,  // mode
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [31:0]                         rsp_tdata,  // edge_value, out_column, out_row
   input  logic                                rsp_tlast,  // frame_last
   output int                                  fail_count,
   output int                                  pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import glre_pkg::*;

   localparam int LINE = 1024;

   typedef struct {
      logic [7:0]           magnitude;
      logic [OCOL_BITS-1:0] column;
      logic [OROW_BITS-1:0] row;
      logic                 last;
   } edge_word_type;

   edge_word_type edge_q[$];

   int unsigned width_px, height_px;
   int unsigned in_col, in_row, out_pos;
   logic [23:0] rgb_lines [0:4*LINE-1];
   logic [23:0] window_px [0:24];
   logic [7:0]  luma_lines [0:2*LINE-1];
   int errs;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned blurred(int shift);
      int unsigned acc;
      acc = 0;
      for (int k = 0; k < 5; k++)
         for (int t = 0; t < 5; t++)
            acc += ((window_px[k*5+t] >> shift) & 8'hFF) * GAUSS_K[k][t];
      return acc / 159;
   endfunction

   function automatic int unsigned root_floor(int unsigned n);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= n) r++;
      return r;
   endfunction

   function automatic int unsigned gap_of(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Advance the frame by one accepted word and queue the edge word it yields
   task automatic advance_frame(logic mode, logic [23:0] word);
      int unsigned v, lpos, lr, lc, epos, er, ec, luma, mag, d1, d2;
      int unsigned rr, gg, bb;
      logic [23:0] pix;
      logic drain;
      edge_word_type ew;
      drain = (in_row >= height_px);
      if (!drain && mode) return;
      if (!drain) begin
         pix = {word[7:0], word[15:8], word[23:16]};
         for (int k = 0; k < 5; k++) begin
            for (int t = 0; t < 4; t++) window_px[k*5+t] = window_px[k*5+t+1];
            window_px[k*5+4] = (k < 4) ? rgb_lines[((in_row + k) & 3) * LINE + in_col] : pix;
         end
         rgb_lines[(in_row & 3) * LINE + in_col] = pix;
         v = in_row * width_px + in_col;
      end else begin
         v = out_pos + 3 * width_px + 3;
      end
      // luma of the blurred pixel two rows plus two columns back
      if (v >= 2 * width_px + 2) begin
         lpos = v - 2 * width_px - 2;
         lr = lpos / width_px;
         lc = lpos % width_px;
         luma = 0;
         if (!drain && lr >= 2 && lr + 3 <= height_px && lc >= 2 && lc + 3 <= width_px) begin
            rr = blurred(16);
            gg = blurred(8);
            bb = blurred(0);
            luma = (LUMA_KR * rr + LUMA_KG * gg + LUMA_KB * bb) >> 16;
         end
         luma_lines[(lr & 1) * LINE + lc] = luma[7:0];
      end
      // Roberts cross one row plus one column further back
      if (v >= 3 * width_px + 3) begin
         epos = v - 3 * width_px - 3;
         er = epos / width_px;
         ec = epos % width_px;
         mag = 0;
         if (er + 1 < height_px && ec + 1 < width_px) begin
            d1 = gap_of(luma_lines[(er & 1) * LINE + ec],
                        luma_lines[((er + 1) & 1) * LINE + ec + 1]);
            d2 = gap_of(luma_lines[(er & 1) * LINE + ec + 1],
                        luma_lines[((er + 1) & 1) * LINE + ec]);
            mag = root_floor(d1 * d1 + d2 * d2);
            if (mag > 255) mag = 255;
         end
         ew.magnitude = mag[7:0];
         ew.column = ec[OCOL_BITS-1:0];
         ew.row = er[OROW_BITS-1:0];
         ew.last = (epos + 1 == width_px * height_px);
         edge_q.push_back(ew);
         out_pos = epos + 1;
      end
      if (!drain) begin
         in_col++;
         if (in_col >= width_px) begin
            in_col = 0;
            in_row++;
         end
      end else if (out_pos >= width_px * height_px) begin
         in_col = 0;
         in_row = 0;
         out_pos = 0;
      end
   endtask

   // Compare one delivered edge word with the oldest prediction
   task automatic compare_edge();
      edge_word_type ew;
      if (edge_q.size() == 0) begin
         $error("edge word with nothing outstanding: tdata=%h tlast=%b", rsp_tdata, rsp_tlast);
         errs++;
         return;
      end
      ew = edge_q.pop_front();
      if (rsp_tdata[7:0] !== ew.magnitude) begin
         $error("edge_value expected %0d actual %0d", ew.magnitude, rsp_tdata[7:0]);
         errs++;
      end
      if (rsp_tdata[17:8] !== ew.column) begin
         $error("out_column expected %0d actual %0d", ew.column, rsp_tdata[17:8]);
         errs++;
      end
      if (rsp_tdata[29:18] !== ew.row) begin
         $error("out_row expected %0d actual %0d", ew.row, rsp_tdata[29:18]);
         errs++;
      end
      if (rsp_tlast !== ew.last) begin
         $error("frame_last expected %0d actual %0d", ew.last, rsp_tlast);
         errs++;
      end
   endtask

   // Track the unit: results first, then register writes, then input words
   always @(posedge clock) begin
      if (reset) begin
         width_px = RESET_WIDTH;
         height_px = RESET_HEIGHT;
         in_col = 0;
         in_row = 0;
         out_pos = 0;
         errs = 0;
         for (int i = 0; i < 25; i++) window_px[i] = '0;
         for (int i = 0; i < 4*LINE; i++) rgb_lines[i] = '0;
         for (int i = 0; i < 2*LINE; i++) luma_lines[i] = '0;
         edge_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_edge();
         if (csr_we) begin
            if (csr_addr == REG_FRAME_WIDTH)
               width_px = clamp_dim(csr_wdata[CFG_W_BITS-1:0], LINE);
            else
               height_px = clamp_dim(csr_wdata[CFG_H_BITS-1:0], 4095);
            in_col = 0;
            in_row = 0;
            out_pos = 0;
         end
         if (req_tvalid && req_tready) advance_frame(req_tuser, req_tdata);
      end
      pending <= edge_q.size();
      fail_count <= errs;
   end

endmodule

/* bench/gaussian_luma_roberts_edge_unit_tb.sv */
// ----------------------------------------------------------------------------
// gaussian_luma_roberts_edge_unit_tb
// Streams RGB frames of several sizes through the edge unit with random
// gaps on both sides, drain words, ignored and misplaced words, and
// register writes at clamped extremes; a checker predicts every edge word.
// ----------------------------------------------------------------------------
module gaussian_luma_roberts_edge_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import glre_pkg::*;

   localparam int TAIL_CYCLES = 60;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic                      csr_addr = REG_FRAME_WIDTH;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [23:0]               req_tdata = '0;  // red, green, blue
   logic                      req_tuser = 1'b0;  // mode
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [31:0]               rsp_tdata;  // edge_value, out_column, out_row
   logic                      rsp_tlast;  // frame_last
   int                        fail_count;
   int                        pending;
   logic                      calm = 1'b0;
   int                        words_sent = 0;

   gaussian_luma_roberts_edge_unit uut (.*);

   glre_edge_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Drain edge words with a random stall before each one
   initial begin
      int stall;
      forever begin
         stall = calm ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Send one word after a random gap and hold it until accepted
   task automatic send_word(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {b, g, r};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // Wait for every edge word, let the unit settle, then write geometry
   task automatic set_geometry(logic [CSR_DATA_BITS-1:0] w, logic [CSR_DATA_BITS-1:0] h);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= REG_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr <= REG_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Stream npix pixels of a pattern, then the drain words if asked
   task automatic stream_frame(int w, int h, int npix, int pattern, bit with_drain);
      logic [23:0] px;
      int cellsz;
      cellsz = $urandom_range(1, 3);
      for (int p = 0; p < npix; p++) begin
         // drop in an ignored drain word now and then
         if ($urandom_range(0, 19) == 0)
            send_word(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
         case (pattern)
            0: px = 24'($urandom);
            1: px = ((((p % w) / cellsz) + ((p / w) / cellsz)) % 2) ? 24'hFFFFFF : 24'h000000;
            2: px = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                     {8{$urandom_range(0, 1) == 1}}};
            default: px = {3{8'((p % w) * 29 + (p / w) * 7)}};
         endcase
         send_word(1'b0, px[7:0], px[15:8], px[23:16]);
      end
      // pixel words during the drain phase act as drain words
      if (with_drain)
         for (int d = 0; d < 3 * w + 3; d++)
            send_word($urandom_range(0, 2) != 0, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      int w, h;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: undersize values clamp to 8x8, extreme pixels first
      set_geometry(12'd0, 12'd5);
      send_word(1'b1, 8'hFF, 8'hFF, 8'hFF);
      send_word(1'b0, 8'h00, 8'h00, 8'h00);
      send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
      send_word(1'b0, 8'hFF, 8'h00, 8'h00);
      send_word(1'b0, 8'h00, 8'hFF, 8'h00);
      send_word(1'b0, 8'h00, 8'h00, 8'hFF);
      stream_frame(8, 8, 59, 1, 1'b1);
      // next frame follows with no register write
      stream_frame(8, 8, 64, 1, 1'b1);

      // Random frames of small sizes, some without idling
      while (words_sent < 400) begin
         w = $urandom_range(8, 12);
         h = $urandom_range(8, 11);
         set_geometry(12'(w), 12'(h));
         calm <= ($urandom_range(0, 3) == 0);
         stream_frame(w, h, w * h, $urandom_range(0, 3), 1'b1);
         calm <= 1'b0;
      end

      // Tall frame at the height limit, cut off by the next write
      set_geometry(12'd8, 12'hFFF);
      stream_frame(8, 4095, 8 * 20, 0, 1'b0);

      // Widest frame, all ones clamp to 1024; cut off 40 pixels into the second row
      set_geometry(12'hFFF, 12'd9);
      calm <= 1'b1;
      stream_frame(1024, 9, 1024 + 40, 0, 1'b0);
      calm <= 1'b0;

      // Finish with one more complete small frame
      set_geometry(12'd9, 12'd8);
      stream_frame(9, 8, 72, 2, 1'b1);

      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/glre_pkg.sv
rtl/core/glre_ram.sv
rtl/core/glre_ctrl.sv
rtl/core/glre_dp.sv
rtl/core/gaussian_luma_roberts_edge_unit.sv
bench/glre_edge_checker.sv
bench/gaussian_luma_roberts_edge_unit_tb.sv
